>>> hdl/idsq_pkg.sv
`default_nettype none

package idsq_pkg;

  localparam int unsigned NUM_SRC = 5;

  // sequencer phases; codes 6 and 7 are never entered and fall back to idle
  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_PUSH_HI = 3'd1,
    PH_PUSH_LO = 3'd2,
    PH_WAIT_A  = 3'd3,
    PH_WAIT_B  = 3'd4,
    PH_FETCH   = 3'd5
  } phase_e;

  localparam logic [1:0]  DELAY_DONE = 2'd2;
  localparam logic [15:0] PC_CANCEL  = 16'h0000;
  localparam logic [15:0] VEC_VBLANK = 16'h0040;
  localparam logic [15:0] VEC_STAT   = 16'h0048;
  localparam logic [15:0] VEC_TIMER  = 16'h0050;
  localparam logic [15:0] VEC_SERIAL = 16'h0058;
  localparam logic [15:0] VEC_JOYPAD = 16'h0060;
  localparam logic [15:0] VEC_NONE   = 16'h0000;

  typedef struct packed {
    logic [NUM_SRC-1:0] enable_bits;
    logic [NUM_SRC-1:0] flag_bits;
    logic [15:0]        pc;
    logic [15:0]        sp;
    logic               halted;
    logic               prefixed;
    logic               master_enable;
    logic               enable_delay;
  } item_t;

  typedef struct packed {
    logic               consumed;
    logic [15:0]        pc_next;
    logic [15:0]        sp_next;
    logic               write_en;
    logic [15:0]        write_addr;
    logic [7:0]         write_data;
    logic [NUM_SRC-1:0] flag_clear;
    logic               halted_next;
    logic               fetch_en;
    logic               master_enable_next;
    logic               enable_delay_next;
  } res_t;

  typedef struct packed {
    phase_e     phase;
    logic [1:0] delay_count;
    logic [2:0] service_bit;
  } seq_state_t;

  // lowest set bit wins; zero when nothing is set
  function automatic logic [2:0] lowest_bit(input logic [NUM_SRC-1:0] v);
    logic [2:0] r;
    r = '0;
    for (int i = NUM_SRC - 1; i >= 0; i--) begin
      if (v[i]) r = 3'(i);
    end
    return r;
  endfunction

  function automatic logic [15:0] vector_of(input logic [2:0] src);
    logic [15:0] v;
    case (src)
      3'd0:    v = VEC_VBLANK;
      3'd1:    v = VEC_STAT;
      3'd2:    v = VEC_TIMER;
      3'd3:    v = VEC_SERIAL;
      3'd4:    v = VEC_JOYPAD;
      default: v = VEC_NONE;
    endcase
    return v;
  endfunction

  function automatic logic [NUM_SRC-1:0] mask_of(input logic [2:0] src);
    logic [NUM_SRC-1:0] m;
    m = '0;
    if (32'(src) < NUM_SRC) m = NUM_SRC'(1) << src;
    return m;
  endfunction

endpackage

`default_nettype wire

>>> hdl/interrupt_dispatch_sequencer_core.sv
// Each input word is registered in the input stage, and its result word in the result
// stage, which drives m_axis.
// Throughput: one word per clock; the input register and the result register
// each advance whenever the stage ahead is empty or being drained.
// Reset (rst_ni low, asynchronous): phase idle, delay count and served source
// zero, both stages empty.
`default_nettype none

module interrupt_dispatch_sequencer_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  // enable_bits[4:0], flag_bits[9:5], pc[25:10], sp[41:26], halted[42],
  // prefixed[43], master_enable[44], enable_delay[45], zero pad[47:46]
  input  wire logic [47:0] s_axis_tdata,
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // consumed[0], pc_next[16:1], sp_next[32:17], write_en[33],
  // write_addr[49:34], write_data[57:50], flag_clear[62:58],
  // halted_next[63], fetch_en[64], master_enable_next[65],
  // enable_delay_next[66], zero pad[71:67]
  output      logic [71:0] m_axis_tdata
);
  import idsq_pkg::*;

  // input stage
  logic       in_vld_q;
  item_t      in_q;
  // result stage
  logic       out_vld_q;
  res_t       out_q;
  // sequencer state, updated when a word passes from input to result stage
  seq_state_t st_q;
  seq_state_t st_d;
  res_t       res_d;
  logic       adv;
  item_t      s_item;

  // unpack the incoming word
  assign s_item.enable_bits   = s_axis_tdata[4:0];
  assign s_item.flag_bits     = s_axis_tdata[9:5];
  assign s_item.pc            = s_axis_tdata[25:10];
  assign s_item.sp            = s_axis_tdata[41:26];
  assign s_item.halted        = s_axis_tdata[42];
  assign s_item.prefixed      = s_axis_tdata[43];
  assign s_item.master_enable = s_axis_tdata[44];
  assign s_item.enable_delay  = s_axis_tdata[45];

  // the result stage frees up in the same cycle it is taken
  assign adv           = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || adv;

  idsq_step u_step (
    .item_i  (in_q),
    .state_i (st_q),
    .res_o   (res_d),
    .state_o (st_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      st_q      <= '{phase: PH_IDLE, delay_count: 2'd0, service_bit: 3'd0};
    end else begin
      if (s_axis_tready) in_vld_q <= s_axis_tvalid;
      if (adv) begin
        out_vld_q <= 1'b1;
        st_q      <= st_d;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) in_q <= s_item;
    if (adv) out_q <= res_d;
  end

  // pack the result word
  assign m_axis_tvalid       = out_vld_q;
  assign m_axis_tdata[0]     = out_q.consumed;
  assign m_axis_tdata[16:1]  = out_q.pc_next;
  assign m_axis_tdata[32:17] = out_q.sp_next;
  assign m_axis_tdata[33]    = out_q.write_en;
  assign m_axis_tdata[49:34] = out_q.write_addr;
  assign m_axis_tdata[57:50] = out_q.write_data;
  assign m_axis_tdata[62:58] = out_q.flag_clear;
  assign m_axis_tdata[63]    = out_q.halted_next;
  assign m_axis_tdata[64]    = out_q.fetch_en;
  assign m_axis_tdata[65]    = out_q.master_enable_next;
  assign m_axis_tdata[66]    = out_q.enable_delay_next;
  assign m_axis_tdata[71:67] = '0;

endmodule

`default_nettype wire

>>> hdl/idsq_step.sv
`default_nettype none

module idsq_step (
  input  idsq_pkg::item_t      item_i,
  input  idsq_pkg::seq_state_t state_i,
  output idsq_pkg::res_t       res_o,
  output idsq_pkg::seq_state_t state_o
);
  import idsq_pkg::*;

  logic [NUM_SRC-1:0] pending;
  logic [1:0]         cnt_inc;
  logic               dly_hit;
  logic               idle_delay;
  logic               idle_ime;
  logic [1:0]         idle_cnt;
  logic               start_ok;
  logic               served_live;
  logic               cancel;
  logic [2:0]         sb_lo;

  assign pending     = item_i.enable_bits & item_i.flag_bits;
  assign cnt_inc     = state_i.delay_count + 2'd1;
  assign dly_hit     = item_i.enable_delay && (cnt_inc == DELAY_DONE);
  assign idle_delay  = item_i.enable_delay && !dly_hit;
  assign idle_ime    = item_i.master_enable || dly_hit;
  assign idle_cnt    = !item_i.enable_delay ? state_i.delay_count :
                       (dly_hit ? 2'd0 : cnt_inc);
  assign start_ok    = (|pending) && !(item_i.halted && !idle_ime) &&
                       !idle_delay && idle_ime;
  assign served_live = |(pending & mask_of(state_i.service_bit));
  assign cancel      = !served_live && !(|pending);
  // retarget to the lowest live source if the served one dropped
  assign sb_lo       = (served_live || !(|pending)) ? state_i.service_bit
                                                    : lowest_bit(pending);

  // next state
  always_comb begin
    state_o = state_i;
    if (!item_i.prefixed) begin
      unique case (state_i.phase)
        PH_IDLE: begin
          state_o.delay_count = idle_cnt;
          if (start_ok && !item_i.halted) begin
            state_o.phase       = PH_PUSH_HI;
            state_o.service_bit = lowest_bit(pending);
          end
        end
        PH_PUSH_HI: state_o.phase = PH_PUSH_LO;
        PH_PUSH_LO: begin
          state_o.phase       = PH_WAIT_A;
          state_o.service_bit = sb_lo;
        end
        PH_WAIT_A:  state_o.phase = PH_WAIT_B;
        PH_WAIT_B:  state_o.phase = PH_FETCH;
        PH_FETCH:   state_o.phase = PH_IDLE;
        default:    state_o.phase = PH_IDLE;
      endcase
    end
  end

  // result word
  always_comb begin
    res_o                    = '0;
    res_o.pc_next            = item_i.pc;
    res_o.sp_next            = item_i.sp;
    res_o.halted_next        = item_i.halted;
    res_o.master_enable_next = item_i.master_enable;
    res_o.enable_delay_next  = item_i.enable_delay;
    if (!item_i.prefixed) begin
      unique case (state_i.phase)
        PH_IDLE: begin
          res_o.master_enable_next = idle_ime;
          res_o.enable_delay_next  = idle_delay;
          if (|pending) begin
            if (item_i.halted && !idle_ime) begin
              res_o.halted_next = 1'b0;
            end else if (start_ok) begin
              res_o.consumed = 1'b1;
              if (item_i.halted) begin
                res_o.halted_next = 1'b0;
              end else begin
                res_o.master_enable_next = 1'b0;
                res_o.pc_next            = item_i.pc - 16'd1;
              end
            end
          end
        end
        PH_PUSH_HI: begin
          res_o.consumed   = 1'b1;
          res_o.sp_next    = item_i.sp - 16'd1;
          res_o.write_en   = 1'b1;
          res_o.write_addr = item_i.sp - 16'd1;
          res_o.write_data = item_i.pc[15:8];
        end
        PH_PUSH_LO: begin
          res_o.consumed   = 1'b1;
          res_o.sp_next    = item_i.sp - 16'd1;
          res_o.write_en   = 1'b1;
          res_o.write_addr = item_i.sp - 16'd1;
          res_o.write_data = item_i.pc[7:0];
          if (cancel) begin
            res_o.pc_next = PC_CANCEL;
          end else begin
            res_o.flag_clear = mask_of(sb_lo);
            res_o.pc_next    = vector_of(sb_lo);
          end
        end
        PH_WAIT_A, PH_WAIT_B: res_o.consumed = 1'b1;
        PH_FETCH: begin
          res_o.fetch_en = 1'b1;
          res_o.pc_next  = item_i.pc + 16'd1;
        end
        default: res_o.consumed = 1'b1;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hdl/idsq_checker.sv
`default_nettype none

module idsq_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [71:0] m_axis_tdata
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // input is only held off behind a stalled result word
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input held off with the result side free");

  // a stack write is always an interrupt cycle and lands at the new SP
  a_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[33] |->
      m_axis_tdata[0] && (m_axis_tdata[49:34] == m_axis_tdata[32:17]))
    else $error("stack write outside dispatch or off SP");

  // opcode fetch cycle is handed back to the core
  a_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[64] |-> !m_axis_tdata[0] && !m_axis_tdata[33])
    else $error("fetch flagged on a consumed cycle");

  // at most one request flag is cleared, and only with a push
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $onehot0(m_axis_tdata[62:58]) &&
      (m_axis_tdata[62:58] == 5'd0 || m_axis_tdata[33]))
    else $error("bad flag clear mask");

endmodule

bind interrupt_dispatch_sequencer_core idsq_checker u_idsq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

>>> verif/tb.sv
`default_nettype none

module tb;
  import idsq_pkg::*;

  localparam int RANDOM_WORDS   = 850;
  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no word moving on either side
  localparam int LONG_HOLD      = 150;   // one long sink stall, well past the pipe depth
  localparam int DRAIN_CYCLES   = 8;     // margin after the last expected result word is out

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;

  interrupt_dispatch_sequencer_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Sequencer shadow: phase, EI delay count and the source being served, updated
  // once per accepted input word.
  // ---------------------------------------------------------------------------
  phase_e     seq_phase;
  logic [1:0] ei_count;
  logic [2:0] served_src;

  res_t cycle_results_q[$];  // outcomes still to come out of m_axis, oldest first
  res_t last_res;            // outcome of the previous word, fed back as core state
  int   words_sent;
  int   mismatches;
  int   burst_left;

  // lowest pending source; only ever asked with something pending
  function automatic logic [2:0] first_src(input logic [4:0] v);
    logic [2:0] r;
    r = 3'd0;
    while (r < 3'd4 && !v[r]) r = r + 3'd1;
    return r;
  endfunction

  function automatic res_t irq_cycle(input item_t it);
    res_t        r;
    logic [4:0]  pend;
    logic [15:0] pc;
    logic [15:0] sp;
    logic        halt;
    logic        ime;
    logic        dly;
    r    = '0;
    pc   = it.pc;
    sp   = it.sp;
    halt = it.halted;
    ime  = it.master_enable;
    dly  = it.enable_delay;
    pend = it.enable_bits & it.flag_bits;
    // a CB-prefixed cycle freezes everything, mid-dispatch too
    if (!it.prefixed) begin
      case (seq_phase)
        PH_IDLE: begin
          if (dly) begin
            ei_count = ei_count + 2'd1;
            if (ei_count == DELAY_DONE) begin
              dly      = 1'b0;
              ime      = 1'b1;
              ei_count = 2'd0;
            end
          end
          if (pend != '0) begin
            if (halt && !ime) begin
              halt = 1'b0;              // wake without servicing
            end else if (!dly && ime) begin
              r.consumed = 1'b1;
              if (halt) begin
                halt = 1'b0;            // wake cycle; dispatch starts next word
              end else begin
                seq_phase  = PH_PUSH_HI;
                ime        = 1'b0;
                served_src = first_src(pend);
                pc         = pc - 16'd1;
              end
            end
          end
        end
        PH_PUSH_HI: begin
          sp           = sp - 16'd1;
          r.write_en   = 1'b1;
          r.write_addr = sp;
          r.write_data = pc[15:8];
          r.consumed   = 1'b1;
          seq_phase    = PH_PUSH_LO;
        end
        PH_PUSH_LO: begin
          sp           = sp - 16'd1;
          r.write_en   = 1'b1;
          r.write_addr = sp;
          r.write_data = pc[7:0];
          r.consumed   = 1'b1;
          seq_phase    = PH_WAIT_A;
          // pending is looked at again here: cancel if all gone, else retarget if the served one dropped
          if (pend == '0) begin
            pc = PC_CANCEL;
          end else begin
            if ((pend & (5'd1 << served_src)) == '0) served_src = first_src(pend);
            r.flag_clear = 5'd1 << served_src;
            case (served_src)
              3'd0:    pc = VEC_VBLANK;
              3'd1:    pc = VEC_STAT;
              3'd2:    pc = VEC_TIMER;
              3'd3:    pc = VEC_SERIAL;
              3'd4:    pc = VEC_JOYPAD;
              default: pc = VEC_NONE;
            endcase
          end
        end
        PH_WAIT_A: begin
          r.consumed = 1'b1;
          seq_phase  = PH_WAIT_B;
        end
        PH_WAIT_B: begin
          r.consumed = 1'b1;
          seq_phase  = PH_FETCH;
        end
        PH_FETCH: begin
          r.fetch_en = 1'b1;
          pc         = pc + 16'd1;
          seq_phase  = PH_IDLE;
        end
        default: begin
          r.consumed = 1'b1;
          seq_phase  = PH_IDLE;
        end
      endcase
    end
    r.pc_next            = pc;
    r.sp_next            = sp;
    r.halted_next        = halt;
    r.master_enable_next = ime;
    r.enable_delay_next  = dly;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Source side: one word at a time, in bursts with random gaps between them.
  // Handshakes are sampled on the falling edge, where every signal has settled.
  // ---------------------------------------------------------------------------
  task automatic offer(input item_t it, input bit typed, input res_t want);
    res_t predicted;
    int   gap;
    s_axis_tdata  <= {2'b00, it.enable_delay, it.master_enable, it.prefixed, it.halted,
                      it.sp, it.pc, it.flag_bits, it.enable_bits};
    s_axis_tvalid <= 1'b1;
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
    predicted = irq_cycle(it);
    last_res  = predicted;
    // hand-typed rows still step the shadow so later rows stay in sync
    cycle_results_q.push_back(typed ? want : predicted);
    words_sent = words_sent + 1;
    burst_left = burst_left - 1;
    if (burst_left <= 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
  endtask

  typedef struct {
    item_t it;
    bit    typed;
    res_t  want;
  } stim_row_t;

  stim_row_t directed_rows[$];

  function automatic void add_row(input logic [4:0] ie, input logic [4:0] ifl,
                                  input logic [15:0] pc, input logic [15:0] sp,
                                  input logic h, input logic p, input logic m,
                                  input logic d, input bit typed, input res_t want);
    stim_row_t row;
    row.it    = '{ie, ifl, pc, sp, h, p, m, d};
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endfunction

  initial begin : stimulus
    item_t it;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    seq_phase     = PH_IDLE;
    ei_count      = 2'd0;
    served_src    = 3'd0;
    last_res      = '0;
    words_sent    = 0;
    mismatches    = 0;
    burst_left    = $urandom_range(1, 24);

    //      ie     if     pc        sp        h     p     ime   dly
    // prefixed with every field at its top: straight pass-through
    add_row(5'h1F, 5'h1F, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
            res_t'{1'b0, 16'hFFFF, 16'hFFFF, 1'b0, 16'h0, 8'h0, 5'h0,
                   1'b1, 1'b0, 1'b1, 1'b1});
    // all zero: nothing pending, nothing moves
    add_row(5'h00, 5'h00, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, '0);
    add_row(5'h1F, 5'h00, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, '0);
    // EI delay: two idle words before IME comes up
    add_row(5'h00, 5'h00, 16'h0100, 16'hFFFE, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, '0);
    add_row(5'h00, 5'h00, 16'h0101, 16'hFFFE, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, '0);
    // halt wake without IME, then with IME (wake only, no dispatch yet)
    add_row(5'h04, 5'h04, 16'h0200, 16'hFFFE, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, '0);
    add_row(5'h04, 5'h04, 16'h0200, 16'hFFFE, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, '0);
    // full vblank dispatch from PC 0 / SP 0, both wrap
    add_row(5'h1F, 5'h1F, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1,
            res_t'{1'b1, 16'hFFFF, 16'h0000, 1'b0, 16'h0, 8'h0, 5'h0,
                   1'b0, 1'b0, 1'b0, 1'b0});
    add_row(5'h1F, 5'h1F, 16'hFFFF, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
            res_t'{1'b1, 16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF, 8'hFF, 5'h0,
                   1'b0, 1'b0, 1'b0, 1'b0});
    add_row(5'h1F, 5'h1F, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
            res_t'{1'b1, VEC_VBLANK, 16'hFFFE, 1'b1, 16'hFFFE, 8'hFF, 5'h01,
                   1'b0, 1'b0, 1'b0, 1'b0});
    add_row(5'h1F, 5'h1E, 16'h0040, 16'hFFFE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, '0);
    add_row(5'h1F, 5'h1E, 16'h0040, 16'hFFFE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, '0);
    add_row(5'h1F, 5'h1E, 16'h0040, 16'hFFFE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, '0);
    // joypad dispatch, request withdrawn before the low push: cancel to 0x0000
    add_row(5'h10, 5'h10, 16'h1234, 16'hC000, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, '0);
    add_row(5'h10, 5'h10, 16'h1233, 16'hC000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, '0);
    add_row(5'h10, 5'h00, 16'h1233, 16'hBFFF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, '0);
    add_row(5'h10, 5'h00, 16'h0000, 16'hBFFE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, '0);
    add_row(5'h10, 5'h00, 16'h0000, 16'hBFFE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, '0);
    add_row(5'h10, 5'h00, 16'h0000, 16'hBFFE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, '0);
    // joypad dispatch with a prefixed stall, then retarget to vblank
    add_row(5'h1F, 5'h10, 16'h8000, 16'h0001, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, '0);
    add_row(5'h1F, 5'h10, 16'h7FFF, 16'h0001, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, '0);
    add_row(5'h1F, 5'h10, 16'h7FFF, 16'h0001, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, '0);
    add_row(5'h1F, 5'h01, 16'h7FFF, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, '0);
    add_row(5'h1F, 5'h00, 16'h0040, 16'hFFFF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, '0);
    add_row(5'h1F, 5'h00, 16'h0040, 16'hFFFF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, '0);
    add_row(5'h1F, 5'h00, 16'h0040, 16'hFFFF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, '0);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) offer(directed_rows[i].it, directed_rows[i].typed,
                                     directed_rows[i].want);

    // Mostly follow the core: carry last outcome forward as the next word's
    // state, with the odd EI or HALT thrown in. A quarter of words are noise.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      it.enable_bits = 5'($urandom);
      it.flag_bits   = 5'($urandom);
      it.prefixed    = ($urandom_range(0, 7) == 0);
      if ($urandom_range(0, 3) != 0) begin
        it.pc            = last_res.pc_next + 16'($urandom_range(0, 2));
        it.sp            = last_res.sp_next;
        it.halted        = last_res.halted_next;
        it.master_enable = last_res.master_enable_next;
        it.enable_delay  = last_res.enable_delay_next;
        if ($urandom_range(0, 5) == 0) it.enable_delay = 1'b1;
        if ($urandom_range(0, 9) == 0) it.halted = 1'b1;
      end else begin
        it.pc            = 16'($urandom);
        it.sp            = 16'($urandom);
        it.halted        = ($urandom_range(0, 3) == 0);
        it.master_enable = ($urandom_range(0, 3) != 0);
        it.enable_delay  = ($urandom_range(0, 3) == 0);
      end
      offer(it, 1'b0, '0);
    end
    s_axis_tvalid <= 1'b0;

    while (cycle_results_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("interrupt_dispatch_sequencer_core regression: pass");
    end else begin
      $display("interrupt_dispatch_sequencer_core regression: fail");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sink side: short choppy stalls, clean stretches, and one long hold-off so
  // the pipe fills and s_axis_tready drops.
  // ---------------------------------------------------------------------------
  initial begin : sink
    bit long_hold_done;
    int hi;
    int lo;
    long_hold_done = 1'b0;
    m_axis_tready  = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 5) == 0) hi = $urandom_range(20, 60);
      else hi = $urandom_range(1, 6);
      lo = $urandom_range(1, 4);
      if (!long_hold_done && words_sent >= 400) begin
        lo             = LONG_HOLD;
        long_hold_done = 1'b1;
      end
      m_axis_tready <= 1'b1;
      repeat (hi) @(posedge clk_i);
      m_axis_tready <= 1'b0;
      repeat (lo) @(posedge clk_i);
    end
  end

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      mismatches = mismatches + 1;
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
    end
  endtask

  // result words are compared at the falling edge before the edge that takes them
  always @(negedge clk_i) begin
    res_t exp_res;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (cycle_results_q.size() == 0) begin
        mismatches = mismatches + 1;
        $display("%0t: unexpected result word %h", $time, m_axis_tdata);
      end else begin
        exp_res = cycle_results_q.pop_front();
        check_field("consumed", 16'(exp_res.consumed), 16'(m_axis_tdata[0]));
        check_field("pc_next", exp_res.pc_next, m_axis_tdata[16:1]);
        check_field("sp_next", exp_res.sp_next, m_axis_tdata[32:17]);
        check_field("write_en", 16'(exp_res.write_en), 16'(m_axis_tdata[33]));
        check_field("write_addr", exp_res.write_addr, m_axis_tdata[49:34]);
        check_field("write_data", 16'(exp_res.write_data), 16'(m_axis_tdata[57:50]));
        check_field("flag_clear", 16'(exp_res.flag_clear), 16'(m_axis_tdata[62:58]));
        check_field("halted_next", 16'(exp_res.halted_next), 16'(m_axis_tdata[63]));
        check_field("fetch_en", 16'(exp_res.fetch_en), 16'(m_axis_tdata[64]));
        check_field("master_enable_next", 16'(exp_res.master_enable_next),
                    16'(m_axis_tdata[65]));
        check_field("enable_delay_next", 16'(exp_res.enable_delay_next),
                    16'(m_axis_tdata[66]));
      end
    end
  end

  // watchdog: too long without a word moving on either side means a hang
  int idle_cycles = 0;
  always @(negedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, idle_cycles);
        $display("interrupt_dispatch_sequencer_core regression: fail");
        $finish;
      end
    end
  end

endmodule

`default_nettype wire
